// ----- rtl/core/vmct_pkg.sv -----
// Shared types, command codes, register indexes and constants for the voice command sender.
package vmct_pkg;

    localparam int unsigned CFG_COUNT = 8;
    localparam int unsigned CFG_INDEX_W = $clog2(CFG_COUNT);
    localparam int unsigned CFG_DATA_W = 8;

    // Command codes carried in a request.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_FRAMED = 3'd1;
    localparam logic [2:0] CMD_SINGLE = 3'd2;
    localparam logic [2:0] CMD_VOLUME = 3'd3;
    localparam logic [2:0] CMD_PLAY   = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_PHASE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_START   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_LONG    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_SHORT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_TRAILER = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LEAD     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BUSY_POLL      = 3'd7;

    // Register reset values.
    localparam logic [7:0] RST_START_LOW      = 8'd5;
    localparam logic [7:0] RST_BIT_PHASE      = 8'd1;
    localparam logic [7:0] RST_SINGLE_START   = 8'd4;
    localparam logic [7:0] RST_SINGLE_LONG    = 8'd3;
    localparam logic [7:0] RST_SINGLE_SHORT   = 8'd1;
    localparam logic [7:0] RST_SINGLE_TRAILER = 8'd100;
    localparam logic [7:0] RST_FRAME_LEAD     = 8'd100;
    localparam logic [7:0] RST_BUSY_POLL      = 8'd10;

    // Frame and single-wire byte constants.
    localparam logic [7:0] FRAME_HEAD   = 8'hF1;
    localparam logic [7:0] FRAME_TAIL   = 8'hF3;
    localparam logic [7:0] VOLUME_BASE  = 8'hE0;
    localparam logic [7:0] PLAY_PAUSE   = 8'hFE;
    localparam logic [2:0] VOLUME_MAX   = 3'd7;
    localparam logic [7:0] TICK_ONE     = 8'h01;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] value;
        logic       busy_level;
    } req_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic single_line;
        logic idle;
        logic dropped;
    } rsp_t;

    typedef struct packed {
        logic [7:0] start_low_ticks;
        logic [7:0] bit_phase_ticks;
        logic [7:0] single_start_ticks;
        logic [7:0] single_long_ticks;
        logic [7:0] single_short_ticks;
        logic [7:0] single_trailer_ticks;
        logic [7:0] frame_lead_ticks;
        logic [7:0] busy_poll_ticks;
    } cfg_t;

endpackage

// ----- rtl/core/vmct_cfg_regs.sv -----
// Timing configuration registers of the voice command sender.
module vmct_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [vmct_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vmct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output vmct_pkg::cfg_t                      cfg
);

    vmct_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks      <= vmct_pkg::RST_START_LOW;
            cfg_reg.bit_phase_ticks      <= vmct_pkg::RST_BIT_PHASE;
            cfg_reg.single_start_ticks   <= vmct_pkg::RST_SINGLE_START;
            cfg_reg.single_long_ticks    <= vmct_pkg::RST_SINGLE_LONG;
            cfg_reg.single_short_ticks   <= vmct_pkg::RST_SINGLE_SHORT;
            cfg_reg.single_trailer_ticks <= vmct_pkg::RST_SINGLE_TRAILER;
            cfg_reg.frame_lead_ticks     <= vmct_pkg::RST_FRAME_LEAD;
            cfg_reg.busy_poll_ticks      <= vmct_pkg::RST_BUSY_POLL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vmct_pkg::REG_START_LOW:      cfg_reg.start_low_ticks      <= cfg_wdata;
                vmct_pkg::REG_BIT_PHASE:      cfg_reg.bit_phase_ticks      <= cfg_wdata;
                vmct_pkg::REG_SINGLE_START:   cfg_reg.single_start_ticks   <= cfg_wdata;
                vmct_pkg::REG_SINGLE_LONG:    cfg_reg.single_long_ticks    <= cfg_wdata;
                vmct_pkg::REG_SINGLE_SHORT:   cfg_reg.single_short_ticks   <= cfg_wdata;
                vmct_pkg::REG_SINGLE_TRAILER: cfg_reg.single_trailer_ticks <= cfg_wdata;
                vmct_pkg::REG_FRAME_LEAD:     cfg_reg.frame_lead_ticks     <= cfg_wdata;
                vmct_pkg::REG_BUSY_POLL:      cfg_reg.busy_poll_ticks      <= cfg_wdata;
                default:                      cfg_reg.start_low_ticks      <= cfg_reg.start_low_ticks;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/vmct_engine.sv -----
// Line sequencer: advances the transfer by one tick per request and registers the pin levels.
module vmct_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  vmct_pkg::cfg_t  cfg,
    input  logic            step_valid,
    input  vmct_pkg::req_t  step_item,
    output logic            step_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output vmct_pkg::rsp_t  rsp
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_POLL,
        PH_LEAD,
        PH_STARTLOW,
        PH_BITLOW,
        PH_BITHIGH,
        PH_SSTART,
        PH_SHIGH,
        PH_SLOW,
        PH_STRAIL
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [1:0]      byte_slot_reg, byte_slot_next;
    logic [2:0]      bit_slot_reg, bit_slot_next;
    logic [7:0]      tick_left_reg, tick_left_next;
    logic [7:0]      shift_byte_reg, shift_byte_next;
    logic [7:0]      frame_cmd_reg, frame_cmd_next;
    logic            clk_pin_reg, clk_pin_next;
    logic            dat_pin_reg, dat_pin_next;
    logic            sgl_pin_reg, sgl_pin_next;
    logic            rsp_valid_reg;
    vmct_pkg::rsp_t  rsp_reg, rsp_next;

    logic            fire;
    logic            dropped;
    logic [2:0]      bit_inc;
    logic [1:0]      byte_inc;
    logic [2:0]      volume;
    logic [7:0]      single_byte;
    logic [7:0]      t_start_low, t_bit_phase, t_single_start, t_single_long;
    logic [7:0]      t_single_short, t_single_trailer, t_frame_lead, t_busy_poll;

    // A zero timing value behaves as one tick.
    function automatic logic [7:0] ticks_of(input logic [7:0] v);
        ticks_of = (v == 8'd0) ? vmct_pkg::TICK_ONE : v;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [1:0] slot, input logic [7:0] fc);
        case (slot)
            2'd0:    frame_byte = vmct_pkg::FRAME_HEAD;
            2'd1:    frame_byte = fc;
            2'd2:    frame_byte = vmct_pkg::FRAME_TAIL;
            default: frame_byte = vmct_pkg::FRAME_HEAD + fc + vmct_pkg::FRAME_TAIL;
        endcase
    endfunction

    assign t_start_low      = ticks_of(cfg.start_low_ticks);
    assign t_bit_phase      = ticks_of(cfg.bit_phase_ticks);
    assign t_single_start   = ticks_of(cfg.single_start_ticks);
    assign t_single_long    = ticks_of(cfg.single_long_ticks);
    assign t_single_short   = ticks_of(cfg.single_short_ticks);
    assign t_single_trailer = ticks_of(cfg.single_trailer_ticks);
    assign t_frame_lead     = ticks_of(cfg.frame_lead_ticks);
    assign t_busy_poll      = ticks_of(cfg.busy_poll_ticks);

    assign step_ready = !rsp_valid_reg || rsp_ready;
    assign fire       = step_valid && step_ready;
    assign bit_inc    = bit_slot_reg + 3'd1;
    assign byte_inc   = byte_slot_reg + 2'd1;

    always_comb
    begin
        volume = (step_item.value > {5'd0, vmct_pkg::VOLUME_MAX}) ? vmct_pkg::VOLUME_MAX
                                                                  : step_item.value[2:0];
        case (step_item.cmd)
            vmct_pkg::CMD_SINGLE: single_byte = step_item.value;
            vmct_pkg::CMD_VOLUME: single_byte = vmct_pkg::VOLUME_BASE | {5'd0, volume};
            default:              single_byte = vmct_pkg::PLAY_PAUSE;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_slot_next  = byte_slot_reg;
        bit_slot_next   = bit_slot_reg;
        tick_left_next  = tick_left_reg;
        shift_byte_next = shift_byte_reg;
        frame_cmd_next  = frame_cmd_reg;
        clk_pin_next    = clk_pin_reg;
        dat_pin_next    = dat_pin_reg;
        sgl_pin_next    = sgl_pin_reg;
        dropped         = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            case (step_item.cmd)
                vmct_pkg::CMD_FRAMED:
                begin
                    frame_cmd_next = step_item.value;
                    byte_slot_next = 2'd0;
                    bit_slot_next  = 3'd0;
                    if (!step_item.busy_level)
                    begin
                        phase_next     = PH_POLL;
                        tick_left_next = t_busy_poll;
                    end
                    else
                    begin
                        phase_next     = PH_LEAD;
                        tick_left_next = t_frame_lead;
                    end
                end
                vmct_pkg::CMD_SINGLE, vmct_pkg::CMD_VOLUME, vmct_pkg::CMD_PLAY:
                begin
                    shift_byte_next = single_byte;
                    bit_slot_next   = 3'd0;
                    sgl_pin_next    = 1'b0;
                    phase_next      = PH_SSTART;
                    tick_left_next  = t_single_start;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // A new request during a transfer is ignored but the transfer still ticks.
            dropped = step_item.cmd inside {[vmct_pkg::CMD_FRAMED:vmct_pkg::CMD_PLAY]};
            if (tick_left_reg > 8'd1)
            begin
                tick_left_next = tick_left_reg - 8'd1;
            end
            else
            begin
                tick_left_next = 8'd0;
                case (phase_reg)
                    PH_POLL:
                    begin
                        if (!step_item.busy_level)
                        begin
                            phase_next     = PH_POLL;
                            tick_left_next = t_busy_poll;
                        end
                        else
                        begin
                            phase_next     = PH_LEAD;
                            tick_left_next = t_frame_lead;
                        end
                    end
                    PH_LEAD:
                    begin
                        byte_slot_next  = 2'd0;
                        shift_byte_next = frame_byte(2'd0, frame_cmd_reg);
                        bit_slot_next   = 3'd0;
                        dat_pin_next    = shift_byte_next[0];
                        clk_pin_next    = 1'b0;
                        phase_next      = PH_STARTLOW;
                        tick_left_next  = t_start_low;
                    end
                    PH_STARTLOW:
                    begin
                        dat_pin_next   = shift_byte_reg[bit_slot_reg];
                        clk_pin_next   = 1'b0;
                        phase_next     = PH_BITLOW;
                        tick_left_next = t_bit_phase;
                    end
                    PH_BITLOW:
                    begin
                        clk_pin_next   = 1'b1;
                        phase_next     = PH_BITHIGH;
                        tick_left_next = t_bit_phase;
                    end
                    PH_BITHIGH:
                    begin
                        if (bit_slot_reg != 3'd7)
                        begin
                            bit_slot_next  = bit_inc;
                            dat_pin_next   = shift_byte_reg[bit_inc];
                            clk_pin_next   = 1'b0;
                            phase_next     = PH_BITLOW;
                            tick_left_next = t_bit_phase;
                        end
                        else if (byte_slot_reg != 2'd3)
                        begin
                            byte_slot_next  = byte_inc;
                            shift_byte_next = frame_byte(byte_inc, frame_cmd_reg);
                            bit_slot_next   = 3'd0;
                            dat_pin_next    = shift_byte_next[0];
                            clk_pin_next    = 1'b0;
                            phase_next      = PH_STARTLOW;
                            tick_left_next  = t_start_low;
                        end
                        else
                        begin
                            dat_pin_next = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                    PH_SSTART:
                    begin
                        sgl_pin_next   = 1'b1;
                        phase_next     = PH_SHIGH;
                        tick_left_next = shift_byte_reg[bit_slot_reg] ? t_single_long
                                                                      : t_single_short;
                    end
                    PH_SHIGH:
                    begin
                        sgl_pin_next   = 1'b0;
                        phase_next     = PH_SLOW;
                        tick_left_next = shift_byte_reg[bit_slot_reg] ? t_single_short
                                                                      : t_single_long;
                    end
                    PH_SLOW:
                    begin
                        sgl_pin_next = 1'b1;
                        if (bit_slot_reg != 3'd7)
                        begin
                            bit_slot_next  = bit_inc;
                            phase_next     = PH_SHIGH;
                            tick_left_next = shift_byte_reg[bit_inc] ? t_single_long
                                                                     : t_single_short;
                        end
                        else
                        begin
                            phase_next     = PH_STRAIL;
                            tick_left_next = t_single_trailer;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        rsp_next.clock_line  = clk_pin_next;
        rsp_next.data_line   = dat_pin_next;
        rsp_next.single_line = sgl_pin_next;
        rsp_next.idle        = (phase_next == PH_IDLE);
        rsp_next.dropped     = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_slot_reg  <= 2'd0;
            bit_slot_reg   <= 3'd0;
            tick_left_reg  <= 8'd0;
            shift_byte_reg <= 8'd0;
            frame_cmd_reg  <= 8'd0;
            clk_pin_reg    <= 1'b1;
            dat_pin_reg    <= 1'b1;
            sgl_pin_reg    <= 1'b1;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg      <= phase_next;
                byte_slot_reg  <= byte_slot_next;
                bit_slot_reg   <= bit_slot_next;
                tick_left_reg  <= tick_left_next;
                shift_byte_reg <= shift_byte_next;
                frame_cmd_reg  <= frame_cmd_next;
                clk_pin_reg    <= clk_pin_next;
                dat_pin_reg    <= dat_pin_next;
                sgl_pin_reg    <= sgl_pin_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/voice_module_command_transmitter.sv -----
// Top level of the voice module command sender: input register, configuration and sequencer.
//
// Each request is one tick of the line timing and produces exactly one response that shows
// the clock, data and single-wire pin levels after that tick, plus idle and dropped flags.
// A request passes an input register and then the sequencer, whose whole state update is
// combinational ahead of the response register, so one request is taken every cycle when
// the output is not stalled. Framed requests (cmd 1) poll the busy pin, wait the lead delay
// and send four bytes on the two-wire link; cmd 2, 3 and 4 send one byte on the single wire.
// A command that arrives while a transfer runs is ignored and flagged in dropped. The user
// must write timing registers through the configuration port only while no transfer is
// running; the block itself does not enforce this.
module voice_module_command_transmitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  vmct_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output vmct_pkg::rsp_t                      rsp,
    input  logic                                cfg_wr_en,
    input  logic [vmct_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vmct_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    vmct_pkg::cfg_t  cfg;
    vmct_pkg::req_t  s1_item_reg;
    logic            s1_valid_reg;
    logic            step_ready;

    assign req_ready = !s1_valid_reg || step_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            s1_item_reg <= req;
        end
    end

    vmct_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vmct_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step_valid (s1_valid_reg),
        .step_item  (s1_item_reg),
        .step_ready (step_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

    // With no transfer running every line rests high.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.idle |-> rsp.clock_line && rsp.data_line && rsp.single_line)
        else $error("idle response with a line driven low");

    // The two-wire link and the single wire are never active together.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (!rsp.clock_line || !rsp.data_line) |-> rsp.single_line)
        else $error("two-wire and single-wire transfers overlap");

    // A registered request with a free response slot must produce a response next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !rsp_valid |=> rsp_valid)
        else $error("registered request did not reach the response register");

endmodule
